>>> sv/kms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kms_pkg
// Shared types and constants of the key matrix scanner.
// ----------------------------------------------------------------------------
package kms_pkg;

	localparam int ROWS_DEF = 8;
	localparam int COLS_DEF = 16;

	localparam int SENSE_W  = 16;
	localparam int MODE_W   = 2;
	localparam int TDATA_W  = 32;
	localparam int TUSER_W  = 1;

	localparam int STROBE_IDX_W = 4;
	localparam int ROW_IDX_W    = 3;
	localparam int ROW_BITS_W   = 16;

	localparam logic [MODE_W-1:0] MODE_ROW   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COL   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_UNION = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SPLIT = 2'd3;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic step;       // apply the accepted sample
		logic cfg_wr;     // load a new scan mode
		logic emit_rows;  // the last accepted sample finished a scan
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_end;   // the sample now at the input finishes the scan
	} dp_status_t;

endpackage

>>> sv/kms_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kms_ctrl
// Handshake controller: takes one sample, then presents its results.
// ----------------------------------------------------------------------------
module kms_ctrl #(
	parameter int ROWS = kms_pkg::ROWS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic                   m_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  kms_pkg::dp_status_t    status,
	output kms_pkg::ctrl_cmd_t     cmd,
	output logic [$clog2(ROWS)-1:0] row_sel
);

	localparam int ROW_W = $clog2(ROWS);

	kms_pkg::state_t state_q, state_nxt;
	logic [ROW_W-1:0] count_q;
	logic             end_q;
	logic             idle;

	assign idle = (state_q == kms_pkg::ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			kms_pkg::ST_IDLE: begin
				if (s_tvalid && s_tready) state_nxt = kms_pkg::ST_EMIT;
			end
			kms_pkg::ST_EMIT: begin
				if (m_tready && m_tlast) state_nxt = kms_pkg::ST_IDLE;
			end
			default: state_nxt = kms_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		// A configuration write wins over a sample offered in the same cycle.
		cfg_ready     = idle;
		s_tready      = idle && !cfg_valid;
		m_tvalid      = !idle;
		m_tlast       = !end_q || (count_q == ROW_W'(ROWS - 1));
		cmd.step      = s_tvalid && s_tready;
		cmd.cfg_wr    = cfg_valid && cfg_ready;
		cmd.emit_rows = end_q;
		row_sel       = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kms_pkg::ST_IDLE;
			count_q <= '0;
			end_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.step) begin
				end_q   <= status.scan_end;
				count_q <= '0;
			end else if (m_tvalid && m_tready && !m_tlast) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

>>> sv/kms_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kms_datapath
// Raw key rows, scan-start snapshot, strobe sequence and result formatting.
// ----------------------------------------------------------------------------
module kms_datapath #(
	parameter int ROWS = kms_pkg::ROWS_DEF,
	parameter int COLS = kms_pkg::COLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kms_pkg::ctrl_cmd_t            cmd,
	input  logic [$clog2(ROWS)-1:0]       row_sel,
	input  logic [kms_pkg::SENSE_W-1:0]   sense,
	input  logic [kms_pkg::MODE_W-1:0]    cfg_data,
	output kms_pkg::dp_status_t           status,
	output logic [kms_pkg::TDATA_W-1:0]   res_data,
	output logic [kms_pkg::TUSER_W-1:0]   res_user
);

	localparam int ROW_W  = $clog2(ROWS);
	localparam int MAXL   = (ROWS > COLS) ? ROWS : COLS;
	localparam int IDX_W  = $clog2(MAXL + 1);
	localparam int HALF   = ROWS / 2;

	logic [kms_pkg::MODE_W-1:0] mode_q;
	logic                       phase_q;
	logic [IDX_W-1:0]           index_q;

	logic [IDX_W-1:0] idx_inc;
	logic [IDX_W-1:0] row_len;
	logic             two_pass;
	logic             first_phase;
	logic             snap_take;
	logic             row_len_done;
	logic             col_len_done;
	logic [COLS-1:0]  pressed_cols;
	logic [COLS-1:0]  col_hit;
	logic [COLS-1:0]  store_w [ROWS];
	logic [ROWS-1:0]  diff;

	assign two_pass     = (mode_q == kms_pkg::MODE_UNION) || (mode_q == kms_pkg::MODE_SPLIT);
	assign first_phase  = (mode_q == kms_pkg::MODE_COL);
	assign idx_inc      = index_q + 1'b1;
	assign row_len      = (mode_q == kms_pkg::MODE_SPLIT) ? IDX_W'(HALF) : IDX_W'(ROWS);
	assign row_len_done = (idx_inc >= row_len);
	assign col_len_done = (idx_inc >= IDX_W'(COLS));
	assign snap_take    = (phase_q == first_phase) && (index_q == '0);

	assign status.scan_end = phase_q ? col_len_done : (row_len_done && !two_pass);

	// Columns beyond the sense width are never seen as pressed.
	for (genvar c = 0; c < COLS; c++) begin : g_col
		if (c < kms_pkg::SENSE_W) begin : g_seen
			assign pressed_cols[c] = ~sense[c];
		end else begin : g_unseen
			assign pressed_cols[c] = 1'b0;
		end
		assign col_hit[c] = (index_q == IDX_W'(c));
	end

	for (genvar r = 0; r < ROWS; r++) begin : g_row
		localparam bit IN_SPLIT = (r >= HALF);

		logic            low_plain;
		logic            low_split;
		logic            low;
		logic            in_lane;
		logic [COLS-1:0] row_nxt;
		logic [COLS-1:0] row_q;
		logic [COLS-1:0] snap_q;

		if (r < kms_pkg::SENSE_W) begin : g_lp
			assign low_plain = ~sense[r];
		end else begin : g_lp_off
			assign low_plain = 1'b0;
		end

		if (IN_SPLIT && (r - HALF) < kms_pkg::SENSE_W) begin : g_ls
			assign low_split = ~sense[r - HALF];
		end else begin : g_ls_off
			assign low_split = 1'b0;
		end

		assign low     = (mode_q == kms_pkg::MODE_SPLIT) ? low_split : low_plain;
		assign in_lane = (mode_q != kms_pkg::MODE_SPLIT) || IN_SPLIT;

		always_comb begin
			row_nxt = row_q;
			if (cmd.step) begin
				if (!phase_q) begin
					if (index_q == IDX_W'(r)) row_nxt = pressed_cols;
				end else if (in_lane) begin
					for (int c = 0; c < COLS; c++) begin
						if (col_hit[c]) begin
							if (low) begin
								row_nxt[c] = 1'b1;
							end else if (mode_q != kms_pkg::MODE_UNION) begin
								row_nxt[c] = 1'b0;
							end
						end
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				row_q  <= '0;
				snap_q <= '0;
			end else begin
				row_q <= row_nxt;
				// The snapshot sees the row as it was before this sample.
				if (cmd.step && snap_take) snap_q <= row_q;
			end
		end

		assign store_w[r] = row_q;
		assign diff[r]    = (row_q != snap_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= kms_pkg::MODE_ROW;
			phase_q <= 1'b0;
			index_q <= '0;
		end else if (cmd.cfg_wr) begin
			mode_q  <= cfg_data;
			phase_q <= (cfg_data == kms_pkg::MODE_COL);
			index_q <= '0;
		end else if (cmd.step) begin
			if (status.scan_end) begin
				phase_q <= first_phase;
				index_q <= '0;
			end else if (!phase_q && row_len_done) begin
				phase_q <= 1'b1;
				index_q <= '0;
			end else begin
				index_q <= idx_inc;
			end
		end
	end

	// Result formatting.
	logic [IDX_W+kms_pkg::STROBE_IDX_W-1:0] idx_ext;
	logic [ROW_W+kms_pkg::ROW_IDX_W-1:0]    row_idx_ext;
	logic [COLS+kms_pkg::ROW_BITS_W-1:0]    row_bits_ext;
	logic [kms_pkg::ROW_IDX_W-1:0]          row_idx;
	logic [kms_pkg::ROW_BITS_W-1:0]         row_bits;
	logic                                   row_chg;
	logic                                   scan_chg;

	assign idx_ext      = {{kms_pkg::STROBE_IDX_W{1'b0}}, index_q};
	assign row_idx_ext  = {{kms_pkg::ROW_IDX_W{1'b0}}, row_sel};
	assign row_bits_ext = {{kms_pkg::ROW_BITS_W{1'b0}}, store_w[row_sel]};

	always_comb begin
		if (cmd.emit_rows) begin
			row_idx  = row_idx_ext[kms_pkg::ROW_IDX_W-1:0];
			row_bits = row_bits_ext[kms_pkg::ROW_BITS_W-1:0];
			row_chg  = diff[row_sel];
			scan_chg = |diff;
		end else begin
			row_idx  = '0;
			row_bits = '0;
			row_chg  = 1'b0;
			scan_chg = 1'b0;
		end
	end

	assign res_data = {6'b0, scan_chg, row_chg, row_bits, row_idx,
	                   idx_ext[kms_pkg::STROBE_IDX_W-1:0], phase_q};
	assign res_user = cmd.emit_rows;

endmodule

>>> sv/key_matrix_scanner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_scanner_top
// Strobe sequencer and raw key store for a key matrix.
// ----------------------------------------------------------------------------
// Each transfer on the s_ channel is one active-low sense sample taken while
// the strobe announced by the previous result was driven. The block updates
// its raw key rows and announces the next strobe on the m_ channel.
// A sample in the middle of a scan yields one result with row_valid (tuser)
// low and tlast high. The sample that ends a scan yields ROWS results, one
// per row in order, each with its change flag and the scan change flag;
// tlast marks the final row.
// Latency: the first result is shown in the cycle after the sample transfer.
// One sample is in work at a time: a new sample is taken only after the final
// result of the previous one is accepted. While the receiver holds tready
// low, the current result stays on the port and s_tready stays low.
// The scan mode is written on the cfg_ channel while the block is idle and
// restarts the scan at the first strobe of that mode; rows keep their bits.
// Reset clears all rows and snapshots, selects row strobe mode and starts at
// the first row; no clearing pass is needed.
// ----------------------------------------------------------------------------
module key_matrix_scanner_top #(
	parameter int ROWS = kms_pkg::ROWS_DEF,
	parameter int COLS = kms_pkg::COLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [kms_pkg::SENSE_W-1:0]   s_tdata,   // [15:0] sense_levels
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [0] strobe_is_column, [4:1] strobe_index, [7:5] row_number,
	// [23:8] row_bits, [24] row_changed, [25] scan_changed, [31:26] zero
	output logic [kms_pkg::TDATA_W-1:0]   m_tdata,
	output logic [kms_pkg::TUSER_W-1:0]   m_tuser,   // [0] row_valid
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kms_pkg::MODE_W-1:0]    cfg_data   // scan_mode
);

	kms_pkg::ctrl_cmd_t      cmd;
	kms_pkg::dp_status_t     status;
	logic [$clog2(ROWS)-1:0] row_sel;

	kms_ctrl #(
		.ROWS(ROWS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.status   (status),
		.cmd      (cmd),
		.row_sel  (row_sel)
	);

	kms_datapath #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.row_sel (row_sel),
		.sense   (s_tdata),
		.cfg_data(cfg_data),
		.status  (status),
		.res_data(m_tdata),
		.res_user(m_tuser)
	);

`ifndef SYNTHESIS
	// Only one sample is in work: no sample is taken while results wait.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("sample accepted while results are pending");

	// A result without a row is always the only result of its sample.
	a_strobe_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> m_tlast)
		else $error("strobe-only result without tlast");

	// After the final result of a sample, the output channel goes quiet.
	a_quiet_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("result shown after the final transfer of a sample");

	// Row results of one scan keep their change summary across the run.
	a_scan_flag_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> $stable(m_tdata[25]))
		else $error("scan change flag moved within one scan's results");
`endif

endmodule

>>> sim/kms_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kms_result_checker
// Watches the sample, result and mode channels of the key matrix scanner,
// keeps its own copy of the raw key rows, predicts every result and compares
// each accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module kms_result_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [kms_pkg::SENSE_W-1:0]   s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [kms_pkg::TDATA_W-1:0]   m_tdata,
	input  logic [kms_pkg::TUSER_W-1:0]   m_tuser,
	input  logic                          m_tlast,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [kms_pkg::MODE_W-1:0]    cfg_data,
	output int                            mismatches,
	output int                            outstanding
);

	localparam int ROWS = kms_pkg::ROWS_DEF;
	localparam int COLS = kms_pkg::COLS_DEF;

	typedef struct {
		logic                             strobe_col;
		logic [kms_pkg::STROBE_IDX_W-1:0] strobe_idx;
		logic                             row_valid;
		logic [kms_pkg::ROW_IDX_W-1:0]    row_idx;
		logic [kms_pkg::ROW_BITS_W-1:0]   row_bits;
		logic                             row_changed;
		logic                             scan_changed;
		logic                             last;
	} row_report_t;

	logic [kms_pkg::ROW_BITS_W-1:0] key_rows [ROWS];
	logic [kms_pkg::ROW_BITS_W-1:0] key_snap [ROWS];
	logic [kms_pkg::MODE_W-1:0]     scan_mode_q;
	logic                           col_pass;
	int                             strobe_pos;
	row_report_t                    pending_reports [$];
	int                             fail_total = 0;

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fail_total++;
			$display("%0t ns: %s expected %h, got %h", $time, field, want, got);
		end
	endtask

	// Applies one sense sample to the key rows and queues the results it causes.
	task automatic apply_sample(input logic [kms_pkg::SENSE_W-1:0] sense);
		logic [kms_pkg::ROW_BITS_W-1:0] pressed;
		logic                           scan_done;
		logic                           any_row_changed;
		int                             pass_len;
		int                             base;
		row_report_t                    rep;
		pressed = ~sense;
		scan_done = 1'b0;
		pass_len = (scan_mode_q == kms_pkg::MODE_SPLIT) ? ROWS / 2 : ROWS;
		if (col_pass == (scan_mode_q == kms_pkg::MODE_COL) && strobe_pos == 0) begin
			for (int r = 0; r < ROWS; r++)
				key_snap[r] = key_rows[r];
		end
		if (!col_pass) begin
			key_rows[strobe_pos] = pressed;
			strobe_pos++;
			if (strobe_pos >= pass_len) begin
				if (scan_mode_q == kms_pkg::MODE_UNION
						|| scan_mode_q == kms_pkg::MODE_SPLIT) begin
					col_pass = 1'b1;
					strobe_pos = 0;
				end else begin
					scan_done = 1'b1;
				end
			end
		end else begin
			base = (scan_mode_q == kms_pkg::MODE_SPLIT) ? ROWS / 2 : 0;
			for (int r = base; r < ROWS; r++) begin
				// A high sense line only clears the bit outside the union mode.
				if (!sense[r - base])
					key_rows[r][strobe_pos] = 1'b1;
				else if (scan_mode_q != kms_pkg::MODE_UNION)
					key_rows[r][strobe_pos] = 1'b0;
			end
			strobe_pos++;
			if (strobe_pos >= COLS)
				scan_done = 1'b1;
		end
		if (scan_done) begin
			col_pass = (scan_mode_q == kms_pkg::MODE_COL);
			strobe_pos = 0;
		end
		rep.strobe_col = col_pass;
		rep.strobe_idx = strobe_pos[kms_pkg::STROBE_IDX_W-1:0];
		if (!scan_done) begin
			rep.row_valid = 1'b0;
			rep.row_idx = '0;
			rep.row_bits = '0;
			rep.row_changed = 1'b0;
			rep.scan_changed = 1'b0;
			rep.last = 1'b1;
			pending_reports.push_back(rep);
		end else begin
			any_row_changed = 1'b0;
			for (int r = 0; r < ROWS; r++)
				if (key_rows[r] != key_snap[r])
					any_row_changed = 1'b1;
			for (int r = 0; r < ROWS; r++) begin
				rep.row_valid = 1'b1;
				rep.row_idx = r[kms_pkg::ROW_IDX_W-1:0];
				rep.row_bits = key_rows[r];
				rep.row_changed = (key_rows[r] != key_snap[r]);
				rep.scan_changed = any_row_changed;
				rep.last = (r == ROWS - 1);
				pending_reports.push_back(rep);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				key_rows[r] = '0;
				key_snap[r] = '0;
			end
			scan_mode_q = kms_pkg::MODE_ROW;
			col_pass = 1'b0;
			strobe_pos = 0;
			pending_reports.delete();
			outstanding <= 0;
		end else begin
			// A result leaving now always belongs to an earlier sample, so compare first.
			if (m_tvalid && m_tready) begin
				if (pending_reports.size() == 0) begin
					fail_total++;
					$display("%0t ns: unexpected result, expected none, got tdata %h tuser %h tlast %b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					row_report_t want;
					want = pending_reports.pop_front();
					check_field("strobe_is_column", want.strobe_col, m_tdata[0]);
					check_field("strobe_index", want.strobe_idx, m_tdata[4:1]);
					check_field("row_number", want.row_idx, m_tdata[7:5]);
					check_field("row_bits", want.row_bits, m_tdata[23:8]);
					check_field("row_changed", want.row_changed, m_tdata[24]);
					check_field("scan_changed", want.scan_changed, m_tdata[25]);
					check_field("tdata padding", '0, m_tdata[31:26]);
					check_field("row_valid", want.row_valid, m_tuser[0]);
					check_field("last", want.last, m_tlast);
				end
			end
			if (cfg_valid && cfg_ready) begin
				scan_mode_q = cfg_data;
				col_pass = (cfg_data == kms_pkg::MODE_COL);
				strobe_pos = 0;
			end
			if (s_tvalid && s_tready)
				apply_sample(s_tdata);
			outstanding <= pending_reports.size();
			mismatches <= fail_total;
		end
	end

endmodule

>>> sim/tb_key_matrix_scanner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_matrix_scanner_top
// Drives sense samples and scan mode writes into the key matrix scanner with
// random gaps and receiver stalls; the result checker beside the block
// predicts and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_key_matrix_scanner_top;

	localparam int ROWS = kms_pkg::ROWS_DEF;
	localparam int COLS = kms_pkg::COLS_DEF;
	localparam int TARGET_SAMPLES = 410;
	localparam int WATCHDOG_LIMIT = 1000;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [kms_pkg::SENSE_W-1:0]  s_tdata = '1;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [kms_pkg::TDATA_W-1:0]  m_tdata;
	logic [kms_pkg::TUSER_W-1:0]  m_tuser;
	logic                         m_tlast;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [kms_pkg::MODE_W-1:0]   cfg_data = kms_pkg::MODE_ROW;

	int mismatches;
	int outstanding;
	int samples_sent = 0;
	int idle_cycles = 0;
	bit steady_send = 1'b0;
	bit steady_recv = 1'b0;

	always #6 clk = ~clk;

	key_matrix_scanner_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	kms_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Sense lines are active low, so most samples press only a few keys.
	function automatic logic [kms_pkg::SENSE_W-1:0] sense_pattern();
		logic [kms_pkg::SENSE_W-1:0] val;
		logic [31:0]                 raw_a;
		logic [31:0]                 raw_b;
		raw_a = $urandom();
		raw_b = $urandom();
		case ($urandom_range(0, 9))
			0: val = '1;
			1: val = '0;
			2, 3: val = ~(16'h1 << $urandom_range(0, kms_pkg::SENSE_W - 1));
			4, 5: val = ~((16'h1 << $urandom_range(0, kms_pkg::SENSE_W - 1))
				| (16'h1 << $urandom_range(0, kms_pkg::SENSE_W - 1)));
			6: val = raw_a[kms_pkg::SENSE_W-1:0] | raw_b[kms_pkg::SENSE_W-1:0];
			default: val = raw_a[kms_pkg::SENSE_W-1:0];
		endcase
		return val;
	endfunction

	function automatic int scan_length(input logic [kms_pkg::MODE_W-1:0] mode);
		case (mode)
			kms_pkg::MODE_ROW:   return ROWS;
			kms_pkg::MODE_COL:   return COLS;
			kms_pkg::MODE_UNION: return ROWS + COLS;
			default:             return ROWS / 2 + COLS;
		endcase
	endfunction

	task automatic send_sample(input logic [kms_pkg::SENSE_W-1:0] val);
		int gap;
		gap = steady_send ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= val;
		do @(posedge clk); while (!s_tready);
		samples_sent++;
	endtask

	// The checker's count is registered and lags its queue, hence the wait on the clock before polling it.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_mode(input logic [kms_pkg::MODE_W-1:0] mode);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : recv_side
		forever begin
			if (steady_recv) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [kms_pkg::SENSE_W-1:0] first_scan [ROWS];
		logic [kms_pkg::MODE_W-1:0]  mode_order [4];
		logic [kms_pkg::MODE_W-1:0]  mode;
		int                          phase;
		int                          count;
		int                          len;

		first_scan = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
			16'hFFFE, 16'h7FFF, 16'h0001, 16'h8000};
		mode_order = '{kms_pkg::MODE_SPLIT, kms_pkg::MODE_UNION, kms_pkg::MODE_ROW,
			kms_pkg::MODE_COL};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Row strobe mode from reset: one full scan with extreme samples,
		// then a partial scan that the mode write below cuts short.
		foreach (first_scan[i])
			send_sample(first_scan[i]);
		send_sample(16'h1234);
		send_sample(16'hFFFF);
		write_mode(kms_pkg::MODE_COL);
		for (int i = 0; i < COLS; i++) begin
			if (i == 0)
				send_sample('0);
			else if (i == COLS - 1)
				send_sample('1);
			else
				send_sample(~(16'h1 << (i % ROWS)));
		end

		phase = 0;
		while (samples_sent < TARGET_SAMPLES) begin
			mode = (phase < 4) ? mode_order[phase] : mode_order[$urandom_range(0, 3)];
			write_mode(mode);
			steady_send = ($urandom_range(0, 3) == 0);
			steady_recv = ($urandom_range(0, 3) == 0);
			len = scan_length(mode);
			count = len * $urandom_range(1, 3);
			if ($urandom_range(0, 3) == 0)
				count += $urandom_range(1, len - 1);
			for (int i = 0; i < count && samples_sent < TARGET_SAMPLES; i++) begin
				send_sample(sense_pattern());
				if ($urandom_range(0, 49) == 0)
					drain_results();
			end
			phase++;
		end

		drain_results();
		repeat (ROWS + 4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
